[rtl/core/fwkr_pkg.sv]
package fwkr_pkg;

    localparam int KEY_W   = 32;
    localparam int OCC_W   = 5;
    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LIST   = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REMOVE,
        BK_LIST
    } back_state_t;

    // command handed from the front queue to the back end
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } cmd_t;

endpackage

[rtl/core/fwkr_front.sv]
module fwkr_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fwkr_pkg::KEY_W-1:0]          s_key,
    input  logic [1:0]                          s_op,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output fwkr_pkg::cmd_t                      cmd
);

    // two-entry command queue
    fwkr_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;
    fwkr_pkg::cmd_t cmd_in;

    always_comb begin
        cmd_in.op  = fwkr_pkg::op_t'(s_op);
        cmd_in.key = s_key;
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/core/fwkr_back.sv]
module fwkr_back #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  fwkr_pkg::cmd_t                      cmd,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fwkr_pkg::status_t                   m_status,
    output logic [fwkr_pkg::KEY_W-1:0]          m_key,
    output logic [fwkr_pkg::OCC_W-1:0]          m_occ,
    output logic                                m_last
);

    localparam int FW = $clog2(DEPTH + 1);

    logic [fwkr_pkg::KEY_W-1:0] entries_reg [DEPTH];
    logic [fwkr_pkg::KEY_W-1:0] up          [DEPTH];
    logic [DEPTH-1:0]           match_reg, match_next;
    logic [DEPTH-1:0]           sh;
    logic [FW-1:0]              fill_reg, fill_next;
    logic [FW-1:0]              cnt_reg, cnt_next;
    logic [FW-1:0]              last_idx;
    fwkr_pkg::back_state_t      state_reg, state_next;

    logic                       m_valid_reg;
    fwkr_pkg::status_t          m_status_reg;
    logic [fwkr_pkg::KEY_W-1:0] m_key_reg;
    logic [fwkr_pkg::OCC_W-1:0] m_occ_reg;
    logic                       m_last_reg;

    logic                       out_free;
    logic                       emit;
    fwkr_pkg::status_t          emit_status;
    logic [fwkr_pkg::KEY_W-1:0] emit_key;
    logic [FW-1:0]              emit_occ;
    logic                       emit_last;
    logic                       add_en, shift_en, rotate_en, match_load;

    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = fill_reg - FW'(1);

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_key    = m_key_reg;
    assign m_occ    = m_occ_reg;
    assign m_last   = m_last_reg;

    // neighbor taps, compare lanes and shift enables per entry
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            up[j]         = entries_reg[(j + 1) % DEPTH];
            match_next[j] = (entries_reg[j] == cmd.key) && (FW'(j) < fill_reg);
            // entries at and above the first match move down by one
            sh[j]         = |(match_reg & ({DEPTH{1'b1}} >> (DEPTH - 1 - j)));
        end
    end

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        cmd_ready   = 1'b0;
        emit        = 1'b0;
        emit_status = fwkr_pkg::STAT_OK;
        emit_key    = '0;
        emit_occ    = fill_reg;
        emit_last   = 1'b1;
        add_en      = 1'b0;
        shift_en    = 1'b0;
        rotate_en   = 1'b0;
        match_load  = 1'b0;
        case (state_reg)
            fwkr_pkg::BK_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.op)
                        fwkr_pkg::OP_ADD: begin
                            if (out_free) begin
                                cmd_ready = 1'b1;
                                emit      = 1'b1;
                                if (fill_reg == FW'(DEPTH)) begin
                                    emit_status = fwkr_pkg::STAT_FULL;
                                end else begin
                                    add_en    = 1'b1;
                                    fill_next = fill_reg + FW'(1);
                                    emit_occ  = fill_reg + FW'(1);
                                end
                            end
                        end
                        fwkr_pkg::OP_COUNT: begin
                            if (out_free) begin
                                cmd_ready = 1'b1;
                                emit      = 1'b1;
                            end
                        end
                        fwkr_pkg::OP_REMOVE: begin
                            cmd_ready  = 1'b1;
                            match_load = 1'b1;
                            state_next = fwkr_pkg::BK_REMOVE;
                        end
                        fwkr_pkg::OP_LIST: begin
                            cmd_ready  = 1'b1;
                            cnt_next   = '0;
                            state_next = fwkr_pkg::BK_LIST;
                        end
                        default: ;
                    endcase
                end
            end
            fwkr_pkg::BK_REMOVE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = fwkr_pkg::BK_IDLE;
                    if (fill_reg == '0) begin
                        emit_status = fwkr_pkg::STAT_EMPTY;
                    end else if (match_reg == '0) begin
                        emit_status = fwkr_pkg::STAT_NOT_FOUND;
                    end else begin
                        shift_en  = 1'b1;
                        fill_next = last_idx;
                        emit_occ  = last_idx;
                    end
                end
            end
            fwkr_pkg::BK_LIST: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (fill_reg == '0) begin
                        emit_status = fwkr_pkg::STAT_EMPTY;
                        state_next  = fwkr_pkg::BK_IDLE;
                    end else begin
                        // head goes out and the ring turns; after fill steps it is back
                        rotate_en = 1'b1;
                        emit_key  = entries_reg[0];
                        emit_last = (cnt_reg == last_idx);
                        cnt_next  = cnt_reg + FW'(1);
                        if (cnt_reg == last_idx) begin
                            state_next = fwkr_pkg::BK_IDLE;
                        end
                    end
                end
            end
            default: state_next = fwkr_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fwkr_pkg::BK_IDLE;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg <= emit_status;
            m_key_reg    <= emit_key;
            m_occ_reg    <= fwkr_pkg::OCC_W'(emit_occ);
            m_last_reg   <= emit_last;
        end
        if (match_load) begin
            match_reg <= match_next;
        end
        for (int j = 0; j < DEPTH; j++) begin
            if (add_en && (FW'(j) == fill_reg)) begin
                entries_reg[j] <= cmd.key;
            end else if (shift_en && sh[j]) begin
                entries_reg[j] <= up[j];
            end else if (rotate_en) begin
                entries_reg[j] <= (FW'(j) == last_idx) ? entries_reg[0] : up[j];
            end
        end
    end

endmodule

[rtl/core/fifo_with_keyed_removal_unit.sv]
// Ordered queue of up to DEPTH signed 32-bit keys with delete by key. Each input item
// carries an op in s_tuser (add, remove, list, count) and a key in s_tdata. Items land
// in a two-entry command queue, so the input side keeps accepting up to two items while
// the back end works or the output waits. Add and count are answered from the idle state,
// remove first registers a compare of every entry and then does the close-up shift, and
// list is accepted first and then gives one result per stored entry (one empty result if
// the queue is empty) as the entries rotate past the head.
// Every item gives at least one result; the final one has m_tlast set. Occupancy is
// reported modulo 32.
module fifo_with_keyed_removal_unit #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // key
    input  logic [1:0]                      s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fwkr_pkg::TDATA_W-1:0]    m_tdata,   // entry_key, occupancy, zero pad
    output logic [1:0]                      m_tuser,   // status
    output logic                            m_tlast
);

    logic                               cmd_valid;
    logic                               cmd_ready;
    fwkr_pkg::cmd_t                     cmd;
    fwkr_pkg::status_t                  res_status;
    logic [fwkr_pkg::KEY_W-1:0]         res_key;
    logic [fwkr_pkg::OCC_W-1:0]         res_occ;

    fwkr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_key     (s_tdata),
        .s_op      (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fwkr_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_status  (res_status),
        .m_key     (res_key),
        .m_occ     (res_occ),
        .m_last    (m_tlast)
    );

    assign m_tuser = res_status;
    assign m_tdata = {3'b000, res_occ, res_key};

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH         = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 250;

    typedef struct {
        fwkr_pkg::status_t          status;
        logic [fwkr_pkg::KEY_W-1:0] entry_key;
        logic [fwkr_pkg::OCC_W-1:0] occ;
        logic                       last;
    } result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [fwkr_pkg::KEY_W-1:0]     s_tdata  = '0;
    logic [1:0]                     s_tuser  = fwkr_pkg::OP_ADD;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [fwkr_pkg::TDATA_W-1:0]   m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;

    // queue contents as the block should hold them, head first
    logic [fwkr_pkg::KEY_W-1:0] model_keys[$];
    result_t                    pending_results[$];

    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;
    int hold_left = 0;
    int stall_left = 0;

    int mismatches      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int op_seen[4]      = '{0, 0, 0, 0};
    int full_drops      = 0;
    int misses          = 0;
    int peak_occ        = 0;
    int input_stalls    = 0;
    int quiet_cycles    = 0;

    fifo_with_keyed_removal_unit #(.DEPTH(QDEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_result(fwkr_pkg::status_t st,
                                        logic [fwkr_pkg::KEY_W-1:0] k, int occ, bit last);
        result_t r;
        r.status    = st;
        r.entry_key = k;
        r.occ       = fwkr_pkg::OCC_W'(occ);
        r.last      = last;
        pending_results.push_back(r);
    endfunction

    // update the queue for one accepted item and record the results it must cause
    function automatic void apply_queue_op(fwkr_pkg::op_t op, logic [fwkr_pkg::KEY_W-1:0] key);
        int n;
        int idx;
        n   = model_keys.size();
        idx = -1;
        case (op)
            fwkr_pkg::OP_ADD: begin
                if (n >= QDEPTH) begin
                    push_result(fwkr_pkg::STAT_FULL, '0, n, 1'b1);
                    full_drops++;
                end else begin
                    model_keys.push_back(key);
                    push_result(fwkr_pkg::STAT_OK, '0, n + 1, 1'b1);
                end
            end
            fwkr_pkg::OP_REMOVE: begin
                if (n == 0) begin
                    push_result(fwkr_pkg::STAT_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (model_keys[i] == key) begin
                            idx = i;
                            break;
                        end
                    end
                    if (idx < 0) begin
                        push_result(fwkr_pkg::STAT_NOT_FOUND, '0, n, 1'b1);
                        misses++;
                    end else begin
                        model_keys.delete(idx);
                        push_result(fwkr_pkg::STAT_OK, '0, n - 1, 1'b1);
                    end
                end
            end
            fwkr_pkg::OP_LIST: begin
                if (n == 0)
                    push_result(fwkr_pkg::STAT_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        push_result(fwkr_pkg::STAT_OK, model_keys[i], n, i == n - 1);
            end
            default: push_result(fwkr_pkg::STAT_OK, '0, n, 1'b1);
        endcase
        if (model_keys.size() > peak_occ)
            peak_occ = model_keys.size();
    endfunction

    function automatic int src_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!src_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic int sink_gap();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [fwkr_pkg::KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return fwkr_pkg::KEY_W'($urandom_range(0, 7));  // small pool, gives duplicates
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // called at a rising edge; leaves s_tvalid high after the handshake
    task automatic send_item(fwkr_pkg::op_t op, logic [fwkr_pkg::KEY_W-1:0] key);
        int gap;
        gap = src_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        apply_queue_op(op, key);
        items_sent++;
        op_seen[op]++;
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected item: status %0d key %h occ %0d last %b",
                         $realtime, m_tuser, m_tdata[fwkr_pkg::KEY_W-1:0],
                         m_tdata[fwkr_pkg::KEY_W +: fwkr_pkg::OCC_W], m_tlast);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (m_tuser !== want.status || m_tdata[fwkr_pkg::KEY_W-1:0] !== want.entry_key
                || m_tdata[fwkr_pkg::KEY_W +: fwkr_pkg::OCC_W] !== want.occ
                || m_tdata[fwkr_pkg::TDATA_W-1:fwkr_pkg::KEY_W+fwkr_pkg::OCC_W] !== '0
                || m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: mismatch on result %0d", $realtime, results_checked);
                $display("    status exp %0d got %0d, key exp %h got %h",
                         want.status, m_tuser, want.entry_key,
                         m_tdata[fwkr_pkg::KEY_W-1:0]);
                $display("    occ exp %0d got %0d, last exp %b got %b, pad %b",
                         want.occ, m_tdata[fwkr_pkg::KEY_W +: fwkr_pkg::OCC_W],
                         want.last, m_tlast,
                         m_tdata[fwkr_pkg::TDATA_W-1:fwkr_pkg::KEY_W+fwkr_pkg::OCC_W]);
            end
        end
    endtask

    // result side: check, then pick next tready (long hold, random stalls, or ready)
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result();
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_idle && $urandom_range(0, 99) < 30) begin
                stall_left = sink_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready)
            input_stalls++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_item(fwkr_pkg::OP_REMOVE, 32'h0000_0000);
        send_item(fwkr_pkg::OP_LIST, $urandom);
        send_item(fwkr_pkg::OP_COUNT, $urandom);
    endtask

    task automatic test_extreme_keys();
        send_item(fwkr_pkg::OP_ADD, 32'h8000_0000);
        send_item(fwkr_pkg::OP_ADD, 32'h7fff_ffff);
        send_item(fwkr_pkg::OP_ADD, 32'h0000_0000);
        send_item(fwkr_pkg::OP_ADD, 32'hffff_ffff);
        send_item(fwkr_pkg::OP_ADD, 32'h0000_0000);
        send_item(fwkr_pkg::OP_LIST, 32'hffff_ffff);
        send_item(fwkr_pkg::OP_COUNT, 32'h0000_0000);
    endtask

    task automatic test_remove_by_key();
        send_item(fwkr_pkg::OP_REMOVE, 32'h1234_5678);   // no match
        send_item(fwkr_pkg::OP_REMOVE, 32'h0000_0000);   // duplicate: nearest head goes
        send_item(fwkr_pkg::OP_LIST, $urandom);
        send_item(fwkr_pkg::OP_REMOVE, 32'h7fff_ffff);   // middle
        send_item(fwkr_pkg::OP_REMOVE, 32'h8000_0000);   // head
        send_item(fwkr_pkg::OP_REMOVE, 32'h0000_0000);   // tail
        send_item(fwkr_pkg::OP_LIST, $urandom);
        send_item(fwkr_pkg::OP_COUNT, $urandom);
    endtask

    // sink held off while adds overrun the queue and a full list backs up
    task automatic test_backpressure_fill();
        src_idle  = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < QDEPTH + 3; i++)
            send_item(fwkr_pkg::OP_ADD, rand_key());
        send_item(fwkr_pkg::OP_LIST, $urandom);
        send_item(fwkr_pkg::OP_COUNT, $urandom);
        send_item(fwkr_pkg::OP_REMOVE, model_keys[QDEPTH / 2]);
        send_item(fwkr_pkg::OP_REMOVE, model_keys[0]);
        send_item(fwkr_pkg::OP_LIST, $urandom);
        src_idle = 1'b1;
    endtask

    task automatic test_random_traffic(int n, int add_pct, bit idle_in, bit idle_out);
        int r;
        logic [fwkr_pkg::KEY_W-1:0] k;
        src_idle  = idle_in;
        sink_idle = idle_out;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                send_item(fwkr_pkg::OP_ADD, rand_key());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    // mostly remove keys that are present so the shift path gets used
                    if (model_keys.size() != 0 && $urandom_range(0, 3) != 0)
                        k = model_keys[$urandom_range(0, model_keys.size() - 1)];
                    else
                        k = rand_key();
                    send_item(fwkr_pkg::OP_REMOVE, k);
                end else if (r < 85) begin
                    send_item(fwkr_pkg::OP_LIST, $urandom);
                end else begin
                    send_item(fwkr_pkg::OP_COUNT, $urandom);
                end
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_extreme_keys();
        test_remove_by_key();
        test_backpressure_fill();
        test_random_traffic(130, 45, 1'b1, 1'b1);
        test_random_traffic(90, 70, 1'b0, 1'b0);
        test_random_traffic(90, 25, 1'b0, 1'b1);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items sent (add %0d, remove %0d, list %0d, count %0d), %0d results checked",
                 items_sent, op_seen[fwkr_pkg::OP_ADD], op_seen[fwkr_pkg::OP_REMOVE],
                 op_seen[fwkr_pkg::OP_LIST], op_seen[fwkr_pkg::OP_COUNT], results_checked);
        $display("full drops %0d, keys not found %0d, peak occupancy %0d, input stall cycles %0d",
                 full_drops, misses, peak_occ, input_stalls);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
